### src/wbs_pkg.sv
// ----------------------------------------------------------------------------
// Word boundary scanner package
// Shared types, widths and codes for the word boundary scanner.
// ----------------------------------------------------------------------------
package wbs_pkg;

  localparam int POSITION_BITS = 16;
  localparam int TABLE_DEPTH   = 256;
  localparam int INDEX_BITS    = $clog2(TABLE_DEPTH);

  localparam int FLAG_START_BIT = 0;
  localparam int FLAG_CONT_BIT  = 1;
  localparam int FLAG_END_BIT   = 2;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_TEXT  = 1'b1;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [2:0]               class_t;

  typedef struct packed {
    logic                  action;
    logic [INDEX_BITS-1:0] byte_value;
    class_t                class_flags;
    logic                  reverse_scan;
    logic                  first_byte;
    logic                  last_byte;
    logic [15:0]           start_position;
  } item_t;

endpackage

### src/wbs_class_table.sv
// ----------------------------------------------------------------------------
// Byte class table
// 256-entry table of class flags with a registered read port and per-entry
// valid bits, so that entries not yet written read as zero after reset.
// ----------------------------------------------------------------------------
module wbs_class_table
  import wbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [INDEX_BITS-1:0] wr_addr,
  input  class_t                wr_data,
  input  logic                  rd_en,
  input  logic [INDEX_BITS-1:0] rd_addr,
  output class_t                rd_data
);

  class_t                 mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;
  class_t                 rd_word;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= entry_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

### src/wbs_scan_engine.sv
// ----------------------------------------------------------------------------
// Scan engine
// Holds the state of the open scan run, updates it for each registered text
// byte and its class flags, and drives the result register.
// ----------------------------------------------------------------------------
module wbs_scan_engine
  import wbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        stage_valid,
  input  item_t       stage_item,
  input  class_t      cls,
  output logic        stage_hold,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] end_position
);

  logic active;
  logic decided;
  pos_t bytes_seen;
  pos_t last_end;
  pos_t final_dist;
  pos_t origin;
  logic reversed;

  logic active_next;
  logic decided_next;
  pos_t bytes_seen_next;
  pos_t last_end_next;
  pos_t final_dist_next;
  pos_t origin_next;
  logic reversed_next;

  logic eff_active;
  logic eff_decided;
  pos_t eff_seen;
  pos_t eff_last;
  pos_t eff_final;
  pos_t eff_origin;
  logic eff_rev;
  logic opener;
  logic closer;
  logic emit;
  logic advance;
  pos_t result_pos;

  always_comb begin
    eff_active  = stage_item.first_byte ? 1'b1 : active;
    eff_decided = stage_item.first_byte ? 1'b0 : decided;
    eff_seen    = stage_item.first_byte ? '0 : bytes_seen;
    eff_last    = stage_item.first_byte ? '0 : last_end;
    eff_final   = stage_item.first_byte ? '0 : final_dist;
    eff_origin  = stage_item.first_byte ? pos_t'(stage_item.start_position) : origin;
    eff_rev     = stage_item.first_byte ? stage_item.reverse_scan : reversed;

    opener = eff_rev ? cls[FLAG_END_BIT] : cls[FLAG_START_BIT];
    closer = eff_rev ? cls[FLAG_START_BIT] : cls[FLAG_END_BIT];

    active_next     = active;
    decided_next    = decided;
    bytes_seen_next = bytes_seen;
    last_end_next   = last_end;
    final_dist_next = final_dist;
    origin_next     = origin;
    reversed_next   = reversed;
    emit            = 1'b0;

    if (stage_item.action == ACTION_TEXT && eff_active) begin
      active_next     = 1'b1;
      decided_next    = eff_decided;
      bytes_seen_next = eff_seen + pos_t'(1);
      last_end_next   = eff_last;
      final_dist_next = eff_final;
      origin_next     = eff_origin;
      reversed_next   = eff_rev;
      if (!eff_decided) begin
        if (eff_seen == '0) begin
          if (!opener) begin
            decided_next    = 1'b1;
            final_dist_next = '0;
          end else if (closer) begin
            last_end_next = pos_t'(1);
          end
        end else if (cls[FLAG_CONT_BIT]) begin
          if (closer) begin
            last_end_next = eff_seen + pos_t'(1);
          end
        end else begin
          decided_next    = 1'b1;
          final_dist_next = closer ? eff_seen + pos_t'(1) : eff_last;
        end
      end
      if (stage_item.last_byte) begin
        emit        = 1'b1;
        active_next = 1'b0;
        if (!decided_next) begin
          decided_next    = 1'b1;
          final_dist_next = last_end_next;
        end
      end
    end

    result_pos = eff_rev ? eff_origin - final_dist_next : eff_origin + final_dist_next;
  end

  assign stage_hold = stage_valid && emit && result_valid && result_stall;
  assign advance    = stage_valid && !stage_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      decided      <= 1'b0;
      bytes_seen   <= '0;
      last_end     <= '0;
      final_dist   <= '0;
      origin       <= '0;
      reversed     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        active     <= active_next;
        decided    <= decided_next;
        bytes_seen <= bytes_seen_next;
        last_end   <= last_end_next;
        final_dist <= final_dist_next;
        origin     <= origin_next;
        reversed   <= reversed_next;
      end
      if (advance && emit) begin
        result_valid <= 1'b1;
        end_position <= 16'(result_pos);
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_emit_closes_run: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> (result_valid && !active))
    else $error("Run still open or no result after the last byte.");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(advance && emit))
    else $error("Result appeared without a last byte.");

  a_first_byte_opens: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_item.action == ACTION_TEXT && stage_item.first_byte &&
     !stage_item.last_byte) |=> (active && bytes_seen == pos_t'(1)))
    else $error("First byte did not open a run.");

  a_hold_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    stage_hold |=> (stage_valid && $stable(stage_item)))
    else $error("Held item was lost.");

endmodule

### src/word_boundary_scanner.sv
// ----------------------------------------------------------------------------
// Word boundary scanner
// An accepted last byte passes the stage register, then the result register.
// Throughput: one transaction per cycle while item_stall is low; the class
// table read and the run state update each take one register stage.
// Reset: synchronous; clears the table valid bits (entries read as zero),
// the run state and both pipeline valids at once.
// ----------------------------------------------------------------------------
module word_boundary_scanner
  import wbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        action,
  input  logic [7:0]  byte_value,
  input  logic [2:0]  class_flags,
  input  logic        reverse_scan,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [15:0] start_position,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] end_position
);

  logic   accept;
  logic   stage_valid;
  logic   stage_hold;
  item_t  stage_item;
  class_t cls;

  assign item_stall = stage_valid && stage_hold;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (!stage_hold) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.action         <= action;
      stage_item.byte_value     <= byte_value;
      stage_item.class_flags    <= class_flags;
      stage_item.reverse_scan   <= reverse_scan;
      stage_item.first_byte     <= first_byte;
      stage_item.last_byte      <= last_byte;
      stage_item.start_position <= start_position;
    end
  end

  wbs_class_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && action == ACTION_WRITE),
    .wr_addr (byte_value),
    .wr_data (class_flags),
    .rd_en   (accept && action == ACTION_TEXT),
    .rd_addr (byte_value),
    .rd_data (cls)
  );

  wbs_scan_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage_item   (stage_item),
    .cls          (cls),
    .stage_hold   (stage_hold),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .end_position (end_position)
  );

endmodule
